// ===== src/indexed_list_engine_top_defines.svh =====
// Assertion macros used by the indexed list engine store module.
`ifndef INDEXED_LIST_ENGINE_TOP_DEFINES_SVH
`define INDEXED_LIST_ENGINE_TOP_DEFINES_SVH

// Checks that a condition implies another in the same cycle.
`define ILE_ASSERT_SAME(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("indexed list engine: same-cycle check failed");

// Checks that a condition implies another in the following cycle.
`define ILE_ASSERT_NEXT(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("indexed list engine: next-cycle check failed");

`endif

// ===== src/ile_pkg.sv =====
// Types and constants shared by the indexed list engine.
package ile_pkg;

  localparam int DEPTH   = 16;
  localparam int VALUE_W = 32;
  localparam int IDX_W   = $clog2(DEPTH);
  localparam int CNT_W   = 5;
  localparam int POS_W   = 5;
  localparam int ACT_W   = 3;
  localparam int ST_W    = 2;
  localparam int OUT_W   = 32;

  typedef enum logic [ACT_W-1:0] {
    ACT_INS_HEAD = 3'd0,
    ACT_INS_TAIL = 3'd1,
    ACT_INS_AT   = 3'd2,
    ACT_DEL_HEAD = 3'd3,
    ACT_DEL_TAIL = 3'd4,
    ACT_DEL_AT   = 3'd5,
    ACT_READ     = 3'd6
  } action_t;

  typedef enum logic [ST_W-1:0] {
    ST_OK        = 2'd0,
    ST_BAD_INDEX = 2'd1,
    ST_EMPTY     = 2'd2,
    ST_FULL      = 2'd3
  } status_t;

  typedef struct packed {
    logic                 valid;
    action_t              action;
    logic [POS_W-1:0]     position;
    logic [VALUE_W-1:0]   value;
  } req_t;

  typedef struct packed {
    logic [OUT_W-1:0]     read_value;
    status_t              status;
    logic [CNT_W-1:0]     count;
  } rsp_t;

endpackage

// ===== src/ile_store.sv =====
// Shifting register array that holds the list and works out each request.
module ile_store (
  input  logic          clk,
  input  logic          rst,
  input  ile_pkg::req_t req,
  output ile_pkg::rsp_t rsp
);
  import ile_pkg::*;

  logic [VALUE_W-1:0] entries      [DEPTH];
  logic [VALUE_W-1:0] entries_next [DEPTH];
  logic [CNT_W-1:0]   count;
  logic [CNT_W-1:0]   count_next;
  logic               do_ins;
  logic               do_del;
  logic [IDX_W-1:0]   at;
  logic               is_full;
  logic               is_empty;
  logic               is_insert;
  logic               is_delete;

  assign is_full   = (count == CNT_W'(DEPTH));
  assign is_empty  = (count == '0);
  assign is_insert = (req.action == ACT_INS_HEAD) || (req.action == ACT_INS_TAIL) ||
                     (req.action == ACT_INS_AT);
  assign is_delete = (req.action == ACT_DEL_HEAD) || (req.action == ACT_DEL_TAIL) ||
                     (req.action == ACT_DEL_AT);

  always_comb begin
    do_ins         = 1'b0;
    do_del         = 1'b0;
    at             = '0;
    rsp.read_value = '0;
    rsp.status     = ST_OK;
    unique case (req.action) inside
      ACT_INS_HEAD, ACT_INS_TAIL, ACT_INS_AT: begin
        if (is_full) begin
          rsp.status = ST_FULL;
        end else if (req.action == ACT_INS_HEAD) begin
          do_ins = 1'b1;
        end else if (req.action == ACT_INS_TAIL) begin
          do_ins = 1'b1;
          at     = count[IDX_W-1:0];
        end else if (CNT_W'(req.position) > count) begin
          rsp.status = ST_BAD_INDEX;
        end else begin
          do_ins = 1'b1;
          at     = req.position[IDX_W-1:0];
        end
      end
      ACT_DEL_HEAD, ACT_DEL_TAIL, ACT_DEL_AT: begin
        if (is_empty) begin
          rsp.status = ST_EMPTY;
        end else if (req.action == ACT_DEL_HEAD) begin
          do_del = 1'b1;
        end else if (req.action == ACT_DEL_TAIL) begin
          do_del = 1'b1;
          at     = IDX_W'(count - CNT_W'(1));
        end else if (CNT_W'(req.position) >= count) begin
          rsp.status = ST_BAD_INDEX;
        end else begin
          do_del = 1'b1;
          at     = req.position[IDX_W-1:0];
        end
      end
      ACT_READ: begin
        if (is_empty) begin
          rsp.status     = ST_EMPTY;
          rsp.read_value = '1;
        end else if (CNT_W'(req.position) >= count) begin
          rsp.status     = ST_BAD_INDEX;
          rsp.read_value = '1;
        end else begin
          rsp.read_value = OUT_W'(signed'(entries[req.position[IDX_W-1:0]]));
        end
      end
      default: begin
        rsp.status = ST_OK;
      end
    endcase

    count_next = count;
    if (req.valid && do_ins) begin
      count_next = count + CNT_W'(1);
    end else if (req.valid && do_del) begin
      count_next = count - CNT_W'(1);
    end
    rsp.count = count_next;
  end

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [VALUE_W-1:0] below;
    logic [VALUE_W-1:0] above;

    if (i == 0) begin : g_first
      assign below = entries[i];
    end else begin : g_rest
      assign below = entries[i-1];
    end

    if (i == DEPTH - 1) begin : g_last
      assign above = entries[i];
    end else begin : g_inner
      assign above = entries[i+1];
    end

    always_comb begin
      entries_next[i] = entries[i];
      if (req.valid && do_ins) begin
        if (IDX_W'(i) == at) begin
          entries_next[i] = req.value;
        end else if (IDX_W'(i) > at) begin
          entries_next[i] = below;
        end
      end else if (req.valid && do_del) begin
        if (IDX_W'(i) >= at) begin
          entries_next[i] = above;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    entries <= entries_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else begin
      count <= count_next;
    end
  end

`include "indexed_list_engine_top_defines.svh"

  `ILE_ASSERT_SAME(a_count_range, 1'b1, count <= CNT_W'(DEPTH))
  `ILE_ASSERT_NEXT(a_idle_holds, !req.valid, $stable(count))
  `ILE_ASSERT_NEXT(a_reject_holds, req.valid && rsp.status != ST_OK, $stable(count))
  `ILE_ASSERT_NEXT(a_insert_grows, req.valid && is_insert && rsp.status == ST_OK,
                   count == CNT_W'($past(count) + CNT_W'(1)))
  `ILE_ASSERT_NEXT(a_delete_shrinks, req.valid && is_delete && rsp.status == ST_OK,
                   count == CNT_W'($past(count) - CNT_W'(1)))

endmodule

// ===== src/indexed_list_engine_top.sv =====
// Top level of the indexed list engine: request register, list store and result register.
//
// The block keeps an ordered list of up to 16 signed 32-bit values, head at index 0.
// A request beat is taken at a rising edge where start is high and busy is low; it
// carries action, position and item_value. Actions insert at the head, the tail or a
// position, delete at the head, the tail or a position, or read at a position.
// Every request gives exactly one result beat: done is high for one cycle with
// read_value, status and count, the number of entries after the request.
// The receiver cannot hold results off; each result is taken in its one cycle.
// The accepted request is held in the request register, then passes through the list
// store into the result register. A new request may follow in every cycle while busy
// is low, as the single shifting register array moves all entries at once so that
// each request completes in one pass.
// Reset clears the list to empty and raises busy for the first cycle after it;
// stored values are not cleared, as only entries below the count are ever read.
module indexed_list_engine_top (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  output logic                              busy,
  input  logic        [ile_pkg::ACT_W-1:0]  action,
  input  logic        [ile_pkg::POS_W-1:0]  position,
  input  logic signed [ile_pkg::VALUE_W-1:0] item_value,
  output logic                              done,
  output logic signed [ile_pkg::OUT_W-1:0]  read_value,
  output logic        [ile_pkg::ST_W-1:0]   status,
  output logic        [ile_pkg::CNT_W-1:0]  count
);
  import ile_pkg::*;

  req_t req;
  rsp_t rsp;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy      <= 1'b1;
      req.valid <= 1'b0;
    end else begin
      busy      <= 1'b0;
      req.valid <= start && !busy;
    end
  end

  always_ff @(posedge clk) begin
    if (start && !busy) begin
      req.action   <= action_t'(action);
      req.position <= position;
      req.value    <= item_value;
    end
  end

  ile_store u_store (
    .clk (clk),
    .rst (rst),
    .req (req),
    .rsp (rsp)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= req.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (req.valid) begin
      read_value <= signed'(rsp.read_value);
      status     <= rsp.status;
      count      <= rsp.count;
    end
  end

endmodule
